/* rtl/wpm_pkg.sv */
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// holds widths, register indexes and the queue entry passed front to back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  localparam int MaxPattern = 16;
  localparam int SymbolBits = 8;
  localparam int PatIdxBits = 4;   // pattern index field
  localparam int LenBits    = 5;   // pattern_length register
  localparam int CntBits    = 17;  // text and emitted counters
  localparam int PosBits    = 16;  // reported start position
  localparam int NumBits    = 5;   // results per request, 0..MaxPattern
  localparam int OffBits    = 4;   // window offset, 0..MaxPattern-1
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = 2;
  localparam int QCntBits   = 3;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 8;

  localparam logic [CntBits-1:0]    MaxText       = 17'h10000;
  localparam logic [SymbolBits-1:0] WildcardReset = 8'd35;
  localparam logic [LenBits-1:0]    LengthReset   = 5'd1;

  // func field codes
  localparam logic FuncPattern = 1'b0;
  localparam logic FuncText    = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgPatternLength  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgWildcardSymbol = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgWildcardEnable = 2'd2;

  typedef struct packed {
    logic [LenBits-1:0]    len;     // effective length, 1..MaxPattern
    logic [SymbolBits-1:0] wc_sym;
    logic                  wc_en;
  } cfg_t;

  typedef struct packed {
    logic                  func;
    logic [SymbolBits-1:0] symbol;
    logic [PatIdxBits-1:0] pattern_index;
    logic                  took;       // text symbol entered the window
    logic                  fin;        // last result of this request closes the text
    logic [NumBits-1:0]    count;      // results to report
    logic [OffBits-1:0]    first_off;  // window offset of the first start position
    logic [PosBits-1:0]    first_pos;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/wpm_front.sv */
// ----------------------------------------------------------------------------
// wpm_front: request front end
// tracks text and emitted counts and works out which results each request owes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wpm_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [wpm_pkg::SymbolBits-1:0]    symbol_i,
  input  logic [wpm_pkg::PatIdxBits-1:0]    pattern_index_i,
  input  logic                              last_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output wpm_pkg::entry_t                   entry_o
);
  import wpm_pkg::*;

  logic [CntBits-1:0] text_cnt_q, text_cnt_d;
  logic [CntBits-1:0] emit_cnt_q, emit_cnt_d;
  logic               is_text, took;
  logic [CntBits-1:0] tc_new, pending;
  logic [CntBits:0]   top, lim, avail;
  logic [NumBits-1:0] num;
  logic               fin;

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i & in_ready_o;
  assign is_text    = (func_i == FuncText);

  always_comb begin
    took    = (text_cnt_q < MaxText);
    tc_new  = took ? text_cnt_q + CntBits'(1) : text_cnt_q;
    pending = tc_new - emit_cnt_q;
    // start positions whose window is complete: s + len <= tc_new
    top     = {1'b0, tc_new} + (CntBits+1)'(1);
    lim     = {1'b0, emit_cnt_q} + {{(CntBits+1-LenBits){1'b0}}, cfg_i.len};
    avail   = (top > lim) ? top - lim : '0;
    if (last_i) begin
      avail = {1'b0, pending};
    end
    num = (avail > (CntBits+1)'(MaxPattern)) ? NumBits'(MaxPattern) : avail[NumBits-1:0];
    fin = last_i &&
          (({1'b0, emit_cnt_q} + {{(CntBits+1-NumBits){1'b0}}, num}) == {1'b0, tc_new});
  end

  always_comb begin
    entry_o.func          = func_i;
    entry_o.symbol        = symbol_i;
    entry_o.pattern_index = pattern_index_i;
    entry_o.took          = is_text & took;
    entry_o.fin           = fin;
    entry_o.count         = is_text ? num : '0;
    entry_o.first_off     = pending[OffBits-1:0] - OffBits'(1);
    entry_o.first_pos     = emit_cnt_q[PosBits-1:0];
  end

  always_comb begin
    text_cnt_d = text_cnt_q;
    emit_cnt_d = emit_cnt_q;
    if (push_o && is_text) begin
      if (last_i) begin
        text_cnt_d = '0;
        emit_cnt_d = '0;
      end else begin
        text_cnt_d = tc_new;
        emit_cnt_d = emit_cnt_q + {{(CntBits-NumBits){1'b0}}, num};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_cnt_q <= '0;
      emit_cnt_q <= '0;
    end else begin
      text_cnt_q <= text_cnt_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wpm_queue.sv */
// ----------------------------------------------------------------------------
// wpm_queue: short request queue
// decouples the front end from the back end, one push and one pop per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  wpm_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output wpm_pkg::entry_t pop_data_o
);
  import wpm_pkg::*;

  entry_t              mem_q [QueueDepth];
  logic [QPtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o     = (cnt_q == QCntBits'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrBits'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrBits'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntBits'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wpm_back.sv */
// ----------------------------------------------------------------------------
// wpm_back: match back end
// holds pattern and text window, compares every window offset, emits results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpm_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wpm_pkg::cfg_t                  cfg_i,
  input  logic                           q_valid_i,
  input  wpm_pkg::entry_t                q_data_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wpm_pkg::PosBits-1:0]    start_position_o,
  output logic                           match_o,
  output logic                           final_res_o
);
  import wpm_pkg::*;

  logic [SymbolBits-1:0] pat_q [MaxPattern];
  logic [SymbolBits-1:0] win_q [MaxPattern];  // index 0 is the newest symbol

  logic               busy_q, busy_d;
  logic [NumBits-1:0] cnt_q, cnt_d;
  logic [OffBits-1:0] off_q, off_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic               took_q, took_d;
  logic               fin_q, fin_d;

  logic                out_valid_q, out_valid_d;
  logic [PosBits-1:0]  out_pos_q;
  logic                out_match_q;
  logic                out_final_q;

  logic [MaxPattern-1:0] pat_wc, win_wc, len_mask, match_vec;
  logic [MaxPattern-1:0] sym_hit [MaxPattern];
  logic                  emit, job_done, complete, hit;

  // wildcard flags per stored symbol
  for (genvar gk = 0; gk < MaxPattern; gk++) begin : g_wc
    assign pat_wc[gk]   = cfg_i.wc_en & (pat_q[gk] == cfg_i.wc_sym);
    assign win_wc[gk]   = cfg_i.wc_en & (win_q[gk] == cfg_i.wc_sym);
    assign len_mask[gk] = (LenBits'(gk) >= cfg_i.len);
  end

  // match of the start position that lies gd symbols back from the newest
  for (genvar gd = 0; gd < MaxPattern; gd++) begin : g_off
    for (genvar gj = 0; gj < MaxPattern; gj++) begin : g_sym
      if (gj <= gd) begin : g_cmp
        assign sym_hit[gd][gj] = (pat_q[gj] == win_q[gd-gj]) | pat_wc[gj] | win_wc[gd-gj];
      end else begin : g_none
        assign sym_hit[gd][gj] = 1'b1;
      end
    end
    assign match_vec[gd] = &(sym_hit[gd] | len_mask);
  end

  assign emit     = busy_q & (~out_valid_q | out_ready_i);
  assign job_done = emit & (cnt_q == NumBits'(1));
  assign pop_o    = q_valid_i & (~busy_q | job_done);
  assign complete = ({1'b0, off_q} + LenBits'(1)) >= cfg_i.len;
  assign hit      = took_q & complete & match_vec[off_q];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    off_d  = off_q;
    pos_d  = pos_q;
    took_d = took_q;
    fin_d  = fin_q;
    if (emit) begin
      cnt_d = cnt_q - NumBits'(1);
      off_d = off_q - OffBits'(1);
      pos_d = pos_q + PosBits'(1);
      if (job_done) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o && (q_data_i.func == FuncText) && (q_data_i.count != '0)) begin
      busy_d = 1'b1;
      cnt_d  = q_data_i.count;
      off_d  = q_data_i.first_off;
      pos_d  = q_data_i.first_pos;
      took_d = q_data_i.took;
      fin_d  = q_data_i.fin;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    pos_q  <= pos_d;
    took_q <= took_d;
    fin_q  <= fin_d;
    if (emit) begin
      out_pos_q   <= pos_q;
      out_match_q <= hit;
      out_final_q <= fin_q & (cnt_q == NumBits'(1));
    end
    if (pop_o && (q_data_i.func == FuncPattern)) begin
      pat_q[q_data_i.pattern_index] <= q_data_i.symbol;
    end
    if (pop_o && q_data_i.took) begin
      win_q[0] <= q_data_i.symbol;
      for (int k = 1; k < MaxPattern; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign start_position_o = out_pos_q;
  assign match_o          = out_match_q;
  assign final_res_o      = out_final_q;

endmodule

`default_nettype wire

/* rtl/wildcard_pattern_matcher.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher: streaming pattern match with a wildcard symbol
// reports for every text start position whether the loaded pattern matches
// ----------------------------------------------------------------------------
// Load the pattern with func 0 requests (symbol at pattern_index), then stream
// text with func 1 requests, marking the final symbol with last. Every text of
// n symbols yields n results in start-position order; the one carrying last
// flushes the positions too close to the end as non-matches and flags the
// final one with final_res. Requests are taken at one per cycle while the queue
// is not full. A text request that releases k results keeps the back end busy
// while it emits them, one result per cycle while out_ready allows: k is one
// in steady state, and up to 16 for the last symbol or after the pattern length
// was shortened mid-text. A result passes through the queue, the back-end job
// registers and the result register. The text counter saturates at 65536
// symbols; later text symbols give no result. Pattern entries never loaded read
// as anything. Config writes are only allowed while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_pattern_matcher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [wpm_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [wpm_pkg::CfgBits-1:0]       cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [wpm_pkg::SymbolBits-1:0]    symbol_i,
  input  logic [wpm_pkg::PatIdxBits-1:0]    pattern_index_i,
  input  logic                              last_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wpm_pkg::PosBits-1:0]       start_position_o,
  output logic                              match_o,
  output logic                              final_res_o
);
  import wpm_pkg::*;

  logic [LenBits-1:0]    pattern_length_q;
  logic [SymbolBits-1:0] wildcard_symbol_q;
  logic                  wildcard_enable_q;
  cfg_t                  cfg;

  logic   q_full, q_valid, push, pop;
  entry_t push_entry, pop_entry;

  // config registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q  <= LengthReset;
      wildcard_symbol_q <= WildcardReset;
      wildcard_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPatternLength:  pattern_length_q  <= cfg_data_i[LenBits-1:0];
        CfgWildcardSymbol: wildcard_symbol_q <= cfg_data_i[SymbolBits-1:0];
        CfgWildcardEnable: wildcard_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, oversize clamps to the pattern store
  always_comb begin
    cfg.wc_sym = wildcard_symbol_q;
    cfg.wc_en  = wildcard_enable_q;
    priority if (pattern_length_q == '0) begin
      cfg.len = LenBits'(1);
    end else if (pattern_length_q > LenBits'(MaxPattern)) begin
      cfg.len = LenBits'(MaxPattern);
    end else begin
      cfg.len = pattern_length_q;
    end
  end

  // front end: counts text, decides which start positions each request reports
  wpm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .symbol_i        (symbol_i),
    .pattern_index_i (pattern_index_i),
    .last_i          (last_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  // queue keeps request order, so pattern loads land after earlier text
  wpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  // back end: pattern store, text window, comparator array, result register
  wpm_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_valid_i        (q_valid),
    .q_data_i         (pop_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .start_position_o (start_position_o),
    .match_o          (match_o),
    .final_res_o      (final_res_o)
  );

endmodule

`default_nettype wire

/* tb/wildcard_pattern_matcher_test.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_test: self-checking bench for the pattern matcher
// loads patterns, streams texts under changing settings and idling, predicts
// every start-position result in the bench and compares them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_pattern_matcher_test;
  import wpm_pkg::*;

  localparam int HalfPeriod     = 4;
  localparam int ResetCycles    = 11;
  localparam int DrainCycles    = 8;     // idle time after the last expected result
  localparam int WatchdogLimit  = 1000;  // cycles with no request or result moving
  localparam int RandomPerPhase = 80;

  typedef struct packed {
    logic [PosBits-1:0] pos;
    logic               hit;
    logic               fin;
  } match_result_t;

  // bench copy of the matcher: pattern, recent text, counters and settings
  class match_scoreboard;
    logic [SymbolBits-1:0] pat_sym [MaxPattern];
    logic [SymbolBits-1:0] recent_text [MaxPattern-1];
    int unsigned           symbols_seen;
    int unsigned           positions_done;
    logic [LenBits-1:0]    len_reg;
    logic [SymbolBits-1:0] wc_sym;
    logic                  wc_en;
    match_result_t         expected_matches [$];
    int                    errors;
    int                    requests;
    int                    checked;
    int                    hits;

    function new();
      len_reg        = LengthReset;
      wc_sym         = WildcardReset;
      wc_en          = 1'b1;
      symbols_seen   = 0;
      positions_done = 0;
      errors         = 0;
      requests       = 0;
      checked        = 0;
      hits           = 0;
    endfunction

    function void set_config(logic [LenBits-1:0] len, logic [SymbolBits-1:0] wsym, logic wen);
      len_reg = len;
      wc_sym  = wsym;
      wc_en   = wen;
    endfunction

    // length register clamped to 1..MaxPattern
    function int unsigned length();
      if (len_reg == 0) return 1;
      if (len_reg > MaxPattern) return MaxPattern;
      return len_reg;
    endfunction

    function bit symbols_agree(logic [SymbolBits-1:0] a, logic [SymbolBits-1:0] b);
      return (a == b) || (wc_en && (a == wc_sym || b == wc_sym));
    endfunction

    function int outstanding();
      return expected_matches.size();
    endfunction

    // accepted request: update the model and queue the results it releases
    function void predict_matches(logic func, logic [SymbolBits-1:0] sym, logic [PatIdxBits-1:0] idx,
                                  logic last);
      int unsigned   m;
      int unsigned   s;
      int unsigned   k;
      int            n;
      bit            took;
      bit            complete;
      logic          hit;
      logic [SymbolBits-1:0] t;
      match_result_t r;
      requests++;
      m = length();
      if (func == FuncPattern) begin
        pat_sym[idx] = sym;
        return;
      end
      took = 1'b0;
      if (symbols_seen < int'(MaxText)) begin
        symbols_seen++;
        took = 1'b1;
      end
      n = 0;
      while (positions_done < symbols_seen && n < MaxPattern) begin
        s        = positions_done;
        complete = (s + m <= symbols_seen);
        hit      = 1'b0;
        // incomplete windows only leave on the last symbol, as misses
        if (!complete && !last) break;
        if (complete && took) begin
          hit = 1'b1;
          for (int unsigned j = 0; j < m; j++) begin
            k = symbols_seen - 1 - s - j;
            t = (k == 0) ? sym : recent_text[k-1];
            if (!symbols_agree(pat_sym[j], t)) hit = 1'b0;
          end
        end
        positions_done++;
        r.pos = PosBits'(s);
        r.hit = hit;
        r.fin = last && (positions_done == symbols_seen);
        expected_matches.insert(expected_matches.size(), r);
        n++;
      end
      if (took) begin
        for (int i = MaxPattern - 2; i > 0; i--) recent_text[i] = recent_text[i-1];
        recent_text[0] = sym;
      end
      if (last) begin
        symbols_seen   = 0;
        positions_done = 0;
      end
    endfunction

    function void check_match(logic [PosBits-1:0] pos, logic hit, logic fin);
      match_result_t e;
      if (expected_matches.size() == 0) begin
        $error("result at start_position %0d with no request outstanding", pos);
        errors++;
        return;
      end
      e = expected_matches.pop_front();
      checked++;
      if (hit) hits++;
      if (pos !== e.pos) begin
        $error("start_position: expected %0d, actual %0d", e.pos, pos);
        errors++;
      end
      if (hit !== e.hit) begin
        $error("match: expected %0b, actual %0b (position %0d)", e.hit, hit, e.pos);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("final_res: expected %0b, actual %0b (position %0d)", e.fin, fin, e.pos);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i     = CfgPatternLength;
  logic [CfgBits-1:0]    cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  func_i          = FuncPattern;
  logic [SymbolBits-1:0] symbol_i        = '0;
  logic [PatIdxBits-1:0] pattern_index_i = '0;
  logic                  last_i          = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [PosBits-1:0]    start_position_o;
  logic                  match_o;
  logic                  final_res_o;

  match_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              stall_cycles  = 0;

  wildcard_pattern_matcher i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .symbol_i         (symbol_i),
    .pattern_index_i  (pattern_index_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .start_position_o (start_position_o),
    .match_o          (match_o),
    .final_res_o      (final_res_o)
  );

  always begin
    #HalfPeriod;
    clk_i = 1'b1;
    #HalfPeriod;
    clk_i = 1'b0;
  end

  // receiver backpressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // results are compared at the edge that takes them, values from before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_match(start_position_o, match_o, final_res_o);
    end
  end

  // watchdog: nothing moving on either channel for too long means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("watchdog: no request or result moved for %0d cycles", WatchdogLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one request, with random sender gaps before it; returns at the accepting edge
  task automatic send_req(input logic func, input logic [SymbolBits-1:0] sym,
                          input logic [PatIdxBits-1:0] idx, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= func;
    symbol_i        <= sym;
    pattern_index_i <= idx;
    last_i          <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_matches(func, sym, idx, last);
  endtask

  // drop valid, let every expected result arrive, then wait out the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // writes all three registers back to back; only call with the block idle
  task automatic write_settings(input logic [CfgBits-1:0] len_data,
                                input logic [CfgBits-1:0] wc_data,
                                input logic [CfgBits-1:0] en_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgPatternLength;
    cfg_data_i  <= len_data;
    @(posedge clk_i);
    cfg_index_i <= CfgWildcardSymbol;
    cfg_data_i  <= wc_data;
    @(posedge clk_i);
    cfg_index_i <= CfgWildcardEnable;
    cfg_data_i  <= en_data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(len_data[LenBits-1:0], wc_data, en_data[0]);
  endtask

  // small alphabet so that matches are common, plus wildcard, extremes and noise
  function automatic logic [SymbolBits-1:0] pick_symbol();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 8'h61 + 8'($urandom_range(2));
    if (r < 62) return sb.wc_sym;
    if (r < 70) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // copy mode repeats the pattern with some corruption
  function automatic logic [SymbolBits-1:0] text_symbol(bit copy, int pos);
    if (copy && $urandom_range(4) != 0) return sb.pat_sym[pos % sb.length()];
    return pick_symbol();
  endfunction

  initial begin : stimulus
    int                    sent;
    int                    tlen;
    int                    split;
    int                    choice;
    bit                    copy;
    logic [SymbolBits-1:0] sym;
    logic [CfgBits-1:0]    len_data;
    logic [CfgBits-1:0]    wc_data;
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 3; ph++) begin
      // idling: receiver-heavy gaps, then sender-heavy, then none
      case (ph)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      if (ph == 0) begin
        // load every pattern entry so no text ever reads an unloaded one;
        // last toggles on loads, where it has no effect
        for (int i = 0; i < MaxPattern; i++) begin
          case (i)
            0:       sym = 8'h00;
            1:       sym = 8'hFF;
            2:       sym = WildcardReset;
            default: sym = 8'h61 + 8'(i % 3);
          endcase
          send_req(FuncPattern, sym, PatIdxBits'(i), i[0]);
        end
        // reset settings: length one, wildcard on
        send_req(FuncText, 8'h00, 4'hF, 1'b0);
        send_req(FuncText, WildcardReset, 4'h0, 1'b0);
        send_req(FuncText, 8'hFF, 4'hA, 1'b1);
        // length zero acts as one, exact matching only
        settle();
        write_settings(8'd0, WildcardReset, 8'd0);
        send_req(FuncText, WildcardReset, 4'h5, 1'b0);
        send_req(FuncText, 8'h00, 4'h0, 1'b1);
        // oversized length clamps to the maximum; short text flushes as misses
        settle();
        write_settings(8'hFF, 8'hFF, 8'd1);
        send_req(FuncText, 8'h61, 4'h0, 1'b0);
        send_req(FuncText, 8'h62, 4'h0, 1'b0);
        send_req(FuncText, 8'h63, 4'h0, 1'b1);
        // length shortened in the middle of a text, wildcard code zero
        settle();
        write_settings(8'd3, 8'h00, 8'd1);
        send_req(FuncText, 8'h61, 4'h0, 1'b0);
        send_req(FuncText, 8'h62, 4'h0, 1'b0);
        send_req(FuncText, 8'h23, 4'h0, 1'b0);
        send_req(FuncText, 8'h61, 4'h0, 1'b0);
        send_req(FuncText, 8'h62, 4'h0, 1'b0);
        settle();
        write_settings(8'd1, 8'h00, 8'd1);
        send_req(FuncText, 8'h63, 4'h0, 1'b0);
        send_req(FuncText, 8'h00, 4'h0, 1'b1);
      end

      // random part: mostly whole texts, some pattern reloads and setting changes
      sent = 0;
      while (sent < RandomPerPhase) begin
        choice = $urandom_range(99);
        if (choice < 15) begin
          repeat ($urandom_range(1, 4)) begin
            send_req(FuncPattern, pick_symbol(), PatIdxBits'($urandom_range(15)),
                     1'($urandom_range(1)));
            sent++;
          end
        end else if (choice < 25) begin
          settle();
          case ($urandom_range(5))
            0:       len_data = 8'($urandom_range(255));  // any length, upper bits as noise
            1:       len_data = 8'd16;
            default: len_data = 8'($urandom_range(1, 6));
          endcase
          wc_data = $urandom_range(1) ? WildcardReset : 8'($urandom_range(255));
          write_settings(len_data, wc_data, 8'($urandom_range(3)));
        end else begin
          tlen  = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
          split = (tlen > 1 && $urandom_range(7) == 0) ? $urandom_range(1, tlen - 1) : 0;
          copy  = $urandom_range(1);
          for (int i = 0; i < tlen; i++) begin
            if (split != 0 && i == split) begin
              // new length mid-text, taken while the block is idle
              settle();
              write_settings(8'($urandom_range(1, 16)), sb.wc_sym, {7'd0, sb.wc_en});
            end
            if ($urandom_range(24) == 0) begin
              send_req(FuncPattern, pick_symbol(), PatIdxBits'($urandom_range(15)),
                       1'($urandom_range(1)));
              sent++;
            end
            send_req(FuncText, text_symbol(copy, i), PatIdxBits'($urandom_range(15)),
                     i == tlen - 1);
            sent++;
          end
        end
      end
    end

    settle();
    $display("%0d requests under three idling mixes, %0d results checked (%0d matches)",
             sb.requests, sb.checked, sb.hits);
    $display("includes clamped lengths, mid-text length changes and pattern reloads");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
